// ----- hdl/minmax_peak_decimator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min/max peak decimator
// Clocked implication checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MINMAX_PEAK_DECIMATOR_CORE_MACROS_SVH
`define MINMAX_PEAK_DECIMATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define MMPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmpd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MMPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmpd assertion failed");

`else

`define MMPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define MMPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/mmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Min/max peak decimator package
// Field widths, register indexes, window constants and the level scaler.
// ----------------------------------------------------------------------------
package mmpd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FACTOR_W   = 16;
   localparam int HEIGHT_W   = 13;
   localparam int LEVEL_W    = 12;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = SAMPLE_W + HEIGHT_W;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);
   localparam logic [FACTOR_W-1:0] COUNT_MAX    = '1;

   localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] MAX_INIT = -16'sd32767;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DECIMATION_FACTOR = 8'd0,
      CSR_WINDOW_HEIGHT     = 8'd1
   } csr_index_type;

   // Offset the sample into 0..65535, scale by the height and keep the upper
   // bits. Results of 4096 and above saturate to the top level.
   function automatic logic [LEVEL_W-1:0] scale_level(
      input logic signed [SAMPLE_W-1:0] v,
      input logic [HEIGHT_W-1:0]        h
   );
      logic [SAMPLE_W-1:0] offset;
      logic [PROD_W-1:0]   prod;
      logic [HEIGHT_W-1:0] scaled;
      offset = {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]};
      prod   = PROD_W'(offset) * PROD_W'(h);
      scaled = prod[PROD_W-1:SAMPLE_W];
      if (scaled[HEIGHT_W-1]) begin
         return '1;
      end
      return scaled[LEVEL_W-1:0];
   endfunction

endpackage

// ----- hdl/mmpd_channels.sv -----
// ----------------------------------------------------------------------------
// Min/max peak decimator channels
// Sample input, level output and register write interfaces.
// ----------------------------------------------------------------------------
interface mmpd_req_if import mmpd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mmpd_rsp_if import mmpd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] low_level;
   logic [LEVEL_W-1:0] high_level;

   modport source (output valid, output low_level, output high_level, input ready);
   modport sink   (input valid, input low_level, input high_level, output ready);
endinterface

interface mmpd_csr_if import mmpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/minmax_peak_decimator_core.sv -----
// ----------------------------------------------------------------------------
// Min/max peak decimator
// Waveform envelope: per window of samples, the scaled minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one signed sample per transaction, with last_sample
//   marking the end of the data. Every decimation_factor samples, or on a
//   sample marked last, one transaction leaves on rsp_port with the window's
//   minimum and maximum scaled to window_height. Other samples produce none.
//   csr_port writes decimation_factor (index 0) and window_height (index 1);
//   it is always ready, and other indexes are ignored. A factor of zero acts
//   as one. Write registers only while no window is in flight.
//   Throughput is one sample per cycle while rsp_port does not stall. A closing
//   sample's window is loaded into the window register when the sample is
//   accepted, and is scaled by the two 16x13 multipliers into the output
//   register once that register is free or being read, raising rsp_port.valid.
//   Reset (synchronous, active high) empties both stages, clears the window
//   and restores the register defaults. When rsp_port stalls, the output and
//   window registers hold one closed window each; req_port is held low while
//   both are occupied and rsp_port is not ready, whatever the next sample.
`include "minmax_peak_decimator_core_macros.svh"

module minmax_peak_decimator_core
   import mmpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   mmpd_req_if.sink   req_port,
   mmpd_rsp_if.source rsp_port,
   mmpd_csr_if.sink   csr_port
);

   logic [FACTOR_W-1:0]        factor_ff, factor_in;
   logic [HEIGHT_W-1:0]        height_ff, height_in;
   logic [FACTOR_W-1:0]        count_ff, count_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;

   logic                       win_valid_ff, win_valid_in;
   logic signed [SAMPLE_W-1:0] win_min_ff, win_min_in;
   logic signed [SAMPLE_W-1:0] win_max_ff, win_max_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]         low_ff, low_in;
   logic [LEVEL_W-1:0]         high_ff, high_in;

   logic                       req_accept;
   logic                       out_advance;
   logic                       win_advance;
   logic [FACTOR_W-1:0]        factor_eff;
   logic signed [SAMPLE_W-1:0] upd_min;
   logic signed [SAMPLE_W-1:0] upd_max;
   logic [FACTOR_W-1:0]        upd_count;
   logic                       window_close;

   assign out_advance    = !rsp_valid_ff || rsp_port.ready;
   assign win_advance    = win_valid_ff && out_advance;
   assign req_port.ready = !win_valid_ff || out_advance;
   assign req_accept     = req_port.valid && req_port.ready;

   assign csr_port.ready = 1'b1;

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.low_level  = low_ff;
   assign rsp_port.high_level = high_ff;

   // Register writes.
   always_comb begin
      factor_in = factor_ff;
      height_in = height_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_DECIMATION_FACTOR: factor_in = csr_port.data[FACTOR_W-1:0];
            CSR_WINDOW_HEIGHT:     height_in = csr_port.data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Window update for the incoming sample.
   always_comb begin
      factor_eff   = (factor_ff == '0) ? FACTOR_RESET : factor_ff;
      upd_min      = (req_port.sample < min_ff) ? req_port.sample : min_ff;
      upd_max      = (req_port.sample > max_ff) ? req_port.sample : max_ff;
      upd_count    = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + FACTOR_W'(1);
      window_close = (upd_count >= factor_eff) || req_port.last_sample;

      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      win_valid_in = win_advance ? 1'b0 : win_valid_ff;
      win_min_in   = win_min_ff;
      win_max_in   = win_max_ff;

      if (req_accept) begin
         if (window_close) begin
            count_in     = '0;
            min_in       = MIN_INIT;
            max_in       = MAX_INIT;
            win_valid_in = 1'b1;
            win_min_in   = upd_min;
            win_max_in   = upd_max;
         end else begin
            count_in = upd_count;
            min_in   = upd_min;
            max_in   = upd_max;
         end
      end
   end

   // Scaling stage into the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      low_in       = low_ff;
      high_in      = high_ff;
      if (win_advance) begin
         rsp_valid_in = 1'b1;
         low_in       = scale_level(win_min_ff, height_ff);
         high_in      = scale_level(win_max_ff, height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_RESET;
         height_ff    <= HEIGHT_RESET;
         count_ff     <= '0;
         min_ff       <= MIN_INIT;
         max_ff       <= MAX_INIT;
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         factor_ff    <= factor_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_min_ff <= win_min_in;
      win_max_ff <= win_max_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
   end

   // A sample marked last always closes a window.
   `MMPD_ASSERT_NEXT(a_last_closes, clock, reset, req_accept && req_port.last_sample, win_valid_ff)

   // A closed window waiting on a stalled output is never dropped.
   `MMPD_ASSERT_NEXT(a_win_held, clock, reset, win_valid_ff && !out_advance, win_valid_ff)

   // The scaled minimum never lies above the scaled maximum.
   `MMPD_ASSERT_SAME(a_level_order, clock, reset, rsp_valid_ff, low_ff <= high_ff)

endmodule
